[hdl/llac_pkg.sv]
// Lid-lock actuator controller: shared types, state and command codes,
// register indexes and reset values. No dependencies.
package llac_pkg;

  // Controller state codes (also used for the commanded state)
  localparam logic [2:0] ST_INIT     = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_RESET    = 3'd2;
  localparam logic [2:0] ST_ACTIVE   = 3'd3;
  localparam logic [2:0] ST_INACTIVE = 3'd4;
  localparam logic [2:0] ST_PROC     = 3'd5;

  // Request command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_SET_CMD   = 3'd1;
  localparam logic [2:0] CMD_FORCE     = 3'd2;
  localparam logic [2:0] CMD_ERR_WRITE = 3'd3;
  localparam logic [2:0] CMD_START     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ERROR_INTERVAL = 3'd0;
  localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd1;
  localparam logic [2:0] REG_ON_DELAY       = 3'd2;
  localparam logic [2:0] REG_OFF_DELAY      = 3'd3;
  localparam logic [2:0] REG_RESET_TIMEOUT  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] ON_DELAY_RST      = 16'd250;
  localparam logic [15:0] OFF_DELAY_RST     = 16'd800;
  localparam logic [15:0] RESET_TIMEOUT_RST = 16'd3000;

  localparam int CNT_W = 17;
  localparam int MS_W  = 10;

  typedef struct packed {
    logic [15:0] error_interval;
    logic        active_level;
    logic [15:0] on_delay_ms;
    logic [15:0] off_delay_ms;
    logic [15:0] reset_timeout_ms;
  } llac_cfg_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [MS_W-1:0] elapsed_ms;
    logic            sensor_level;
    logic [2:0]      arg;
  } llac_item_t;

  typedef struct packed {
    logic [2:0]       ctrl_state;
    logic [2:0]       target_state;
    logic [CNT_W-1:0] lock_confirm_count;
    logic [CNT_W-1:0] unlock_confirm_count;
    logic [15:0]      mismatch_count;
    logic [CNT_W-1:0] seek_elapsed;
    logic             drive_level;
    logic             error_bit;
  } llac_state_t;

endpackage

[hdl/llac_step.sv]
// Lid-lock actuator controller: next-state logic for one request.
// Pure combinational; depends on llac_pkg.
module llac_step (
  input  llac_pkg::llac_cfg_t   cfg,
  input  llac_pkg::llac_item_t  item,
  input  llac_pkg::llac_state_t cur,
  output llac_pkg::llac_state_t nxt
);
  import llac_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [MS_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W + 1 - MS_W){1'b0}}, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  logic             engaged;
  logic [15:0]      mm_sum;
  logic             mm_hit;
  logic [CNT_W-1:0] lock_sum;
  logic [CNT_W-1:0] unlock_sum;
  logic [CNT_W-1:0] seek_sum;
  logic [CNT_W-1:0] ms_ext;

  assign engaged    = (item.sensor_level == cfg.active_level);
  assign mm_sum     = cur.mismatch_count + {6'd0, item.elapsed_ms};
  assign mm_hit     = (mm_sum >= cfg.error_interval);
  assign lock_sum   = sat_add(cur.lock_confirm_count, item.elapsed_ms);
  assign unlock_sum = sat_add(cur.unlock_confirm_count, item.elapsed_ms);
  assign seek_sum   = sat_add(cur.seek_elapsed, item.elapsed_ms);
  assign ms_ext     = {{(CNT_W - MS_W){1'b0}}, item.elapsed_ms};

  always_comb begin
    nxt = cur;
    case (item.cmd)
      CMD_TICK: begin
        case (cur.ctrl_state)
          ST_IDLE: nxt.ctrl_state = ST_RESET;
          ST_ACTIVE: begin
            if (cur.target_state == ST_INACTIVE) nxt.ctrl_state = ST_PROC;
          end
          ST_INACTIVE: begin
            if (cur.target_state == ST_ACTIVE) nxt.ctrl_state = ST_PROC;
          end
          ST_PROC: begin
            nxt.drive_level = 1'b1;
            if (cur.target_state == ST_ACTIVE) begin
              if (engaged) begin
                nxt.mismatch_count = '0;
                nxt.lock_confirm_count = lock_sum;
                if (lock_sum >= {1'b0, cfg.on_delay_ms}) begin
                  nxt.drive_level        = 1'b0;
                  nxt.ctrl_state         = ST_ACTIVE;
                  nxt.lock_confirm_count = '0;
                end
              end else if (mm_hit) begin
                nxt.mismatch_count = '0;
                nxt.error_bit      = 1'b1;
              end else begin
                nxt.mismatch_count = mm_sum;
              end
            end else if (cur.target_state == ST_INACTIVE) begin
              if (!engaged) begin
                nxt.mismatch_count = '0;
                nxt.unlock_confirm_count = unlock_sum;
                if (unlock_sum >= {1'b0, cfg.off_delay_ms}) begin
                  nxt.drive_level          = 1'b0;
                  nxt.ctrl_state           = ST_INACTIVE;
                  nxt.unlock_confirm_count = '0;
                end
              end else if (mm_hit) begin
                nxt.mismatch_count = '0;
                nxt.error_bit      = 1'b1;
              end else begin
                nxt.mismatch_count = mm_sum;
              end
            end
          end
          ST_RESET: begin
            nxt.seek_elapsed = seek_sum;
            nxt.drive_level  = 1'b1;
            if (engaged) begin
              nxt.unlock_confirm_count = ms_ext;
            end else if (cur.unlock_confirm_count != '0) begin
              nxt.unlock_confirm_count = unlock_sum;
              if (unlock_sum >= {1'b0, cfg.off_delay_ms}) begin
                nxt.drive_level          = 1'b0;
                nxt.ctrl_state           = ST_INACTIVE;
                nxt.unlock_confirm_count = '0;
              end
            end
            // Seek timeout with a released sensor ends the search
            if (seek_sum >= {1'b0, cfg.reset_timeout_ms} && !engaged) begin
              nxt.drive_level = 1'b0;
              nxt.ctrl_state  = ST_INACTIVE;
            end
          end
          default: ;
        endcase
      end
      CMD_SET_CMD:   nxt.target_state = item.arg;
      CMD_FORCE:     nxt.ctrl_state   = item.arg;
      CMD_ERR_WRITE: nxt.error_bit    = (item.arg != 3'd0);
      CMD_START:     nxt.ctrl_state   = ST_IDLE;
      default: ;
    endcase
  end

endmodule

[hdl/lid_lock_actuator_controller_unit.sv]
// Lid-lock actuator controller, top level: stream ports, input register,
// controller state, result register. Depends on llac_pkg and llac_step.
//
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless the result side stalls; the only loop is
// the controller state register through llac_step, a few 17-bit adds and compares deep.
// Reset (rst, synchronous, active high): state init, commanded state idle,
// counters, drive and error cleared, registers to their defaults, no result.
module lid_lock_actuator_controller_unit (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // elapsed_ms[9:0], sensor_level[10], arg[13:11], zero
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // drive_on[0], actual_state[3:1], error_flag[4],
                                     // commanded_state[7:5]
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import llac_pkg::*;

  llac_cfg_t   cfg;
  llac_state_t st;
  llac_state_t st_next;

  // Input register
  logic        in_valid;
  llac_item_t  in_item;

  // Result register
  logic        out_valid;
  logic [7:0]  out_data;

  logic        in_advance;

  // Move the held request into the result register when that slot is free
  // or being emptied this cycle; the input side refills in the same edge.
  assign in_advance    = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  llac_step u_step (
    .cfg  (cfg),
    .item (in_item),
    .cur  (st),
    .nxt  (st_next)
  );

  // Configuration registers; writes must arrive only while the block is idle; the user keeps to this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_interval   <= '0;
      cfg.active_level     <= 1'b1;
      cfg.on_delay_ms      <= ON_DELAY_RST;
      cfg.off_delay_ms     <= OFF_DELAY_RST;
      cfg.reset_timeout_ms <= RESET_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ERROR_INTERVAL: cfg.error_interval   <= cfg_data;
        REG_ACTIVE_LEVEL:   cfg.active_level     <= cfg_data[0];
        REG_ON_DELAY:       cfg.on_delay_ms      <= cfg_data;
        REG_OFF_DELAY:      cfg.off_delay_ms     <= cfg_data;
        REG_RESET_TIMEOUT:  cfg.reset_timeout_ms <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input register: capture a request whenever the slot is open
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd          <= s_axis_tuser;
      in_item.elapsed_ms   <= s_axis_tdata[9:0];
      in_item.sensor_level <= s_axis_tdata[10];
      in_item.arg          <= s_axis_tdata[13:11];
    end
  end

  // Controller state: advance once per request as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.ctrl_state           <= ST_INIT;
      st.target_state         <= ST_IDLE;
      st.lock_confirm_count   <= '0;
      st.unlock_confirm_count <= '0;
      st.mismatch_count       <= '0;
      st.seek_elapsed         <= '0;
      st.drive_level          <= 1'b0;
      st.error_bit            <= 1'b0;
    end else if (in_advance) begin
      st <= st_next;
    end
  end

  // Result register: hold until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      out_data <= {st_next.target_state, st_next.error_bit,
                   st_next.ctrl_state, st_next.drive_level};
    end
  end

endmodule

[verif/llac_checker.sv]
// Lid-lock actuator controller checker: watches the request, result and
// configuration ports, predicts each status result and compares it.
// Depends on llac_pkg.
module llac_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // elapsed_ms[9:0], sensor_level[10], arg[13:11], zero
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // drive_on[0], actual_state[3:1], error_flag[4],
                                     // commanded_state[7:5]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import llac_pkg::*;

  typedef struct packed {
    logic [2:0] commanded_state;
    logic       error_flag;
    logic [2:0] actual_state;
    logic       drive_on;
  } lock_status_t;

  // register copy
  logic [15:0] err_interval;
  logic        sense_level;
  logic [15:0] lock_delay;
  logic [15:0] unlock_delay;
  logic [15:0] seek_timeout;

  // controller copy
  logic [2:0]  ctrl;
  logic [2:0]  target;
  logic [16:0] lock_cnt;
  logic [16:0] unlock_cnt;
  logic [15:0] mis_cnt;
  logic [16:0] seek_cnt;
  logic        drive;
  logic        err;

  lock_status_t status_due[$];
  lock_status_t seen;
  lock_status_t due;

  function automatic logic [16:0] add_sat17(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? 17'h1FFFF : s[16:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // mismatch timer wraps at 16 bits; reaching the interval raises the error
  task automatic add_mismatch(input logic [9:0] ms);
    mis_cnt = mis_cnt + 16'(ms);
    if (mis_cnt >= err_interval) begin
      mis_cnt = '0;
      err = 1'b1;
    end
  endtask

  task automatic tick_controller(input logic [9:0] ms, input logic engaged);
    case (ctrl)
      ST_IDLE: ctrl = ST_RESET;
      ST_ACTIVE: if (target == ST_INACTIVE) ctrl = ST_PROC;
      ST_INACTIVE: if (target == ST_ACTIVE) ctrl = ST_PROC;
      ST_PROC: begin
        drive = 1'b1;
        if (target == ST_ACTIVE) begin
          if (engaged) begin
            mis_cnt = '0;
            lock_cnt = add_sat17(lock_cnt, 17'(ms));
            if (lock_cnt >= lock_delay) begin
              drive = 1'b0;
              ctrl = ST_ACTIVE;
              lock_cnt = '0;
            end
          end else begin
            add_mismatch(ms);
          end
        end else if (target == ST_INACTIVE) begin
          if (!engaged) begin
            mis_cnt = '0;
            unlock_cnt = add_sat17(unlock_cnt, 17'(ms));
            if (unlock_cnt >= unlock_delay) begin
              drive = 1'b0;
              ctrl = ST_INACTIVE;
              unlock_cnt = '0;
            end
          end else begin
            add_mismatch(ms);
          end
        end
      end
      ST_RESET: begin
        seek_cnt = add_sat17(seek_cnt, 17'(ms));
        drive = 1'b1;
        if (engaged) begin
          unlock_cnt = 17'(ms);
        end else if (unlock_cnt != 0) begin
          unlock_cnt = add_sat17(unlock_cnt, 17'(ms));
          if (unlock_cnt >= unlock_delay) begin
            drive = 1'b0;
            ctrl = ST_INACTIVE;
            unlock_cnt = '0;
          end
        end
        // seek timer is never cleared, so a later seek may end at once
        if (seek_cnt >= seek_timeout && !engaged) begin
          drive = 1'b0;
          ctrl = ST_INACTIVE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic step_controller(input logic [2:0] cmd, input logic [9:0] ms,
                                 input logic lvl, input logic [2:0] arg);
    case (cmd)
      CMD_TICK:      tick_controller(ms, lvl == sense_level);
      CMD_SET_CMD:   target = arg;
      CMD_FORCE:     ctrl = arg;
      CMD_ERR_WRITE: err = (arg != 0);
      CMD_START:     ctrl = ST_IDLE;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      err_interval = '0;
      sense_level  = 1'b1;
      lock_delay   = ON_DELAY_RST;
      unlock_delay = OFF_DELAY_RST;
      seek_timeout = RESET_TIMEOUT_RST;
      ctrl         = ST_INIT;
      target       = ST_IDLE;
      lock_cnt     = '0;
      unlock_cnt   = '0;
      mis_cnt      = '0;
      seek_cnt     = '0;
      drive        = 1'b0;
      err          = 1'b0;
      mismatches   = 0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ERROR_INTERVAL: err_interval = cfg_data;
          REG_ACTIVE_LEVEL:   sense_level  = cfg_data[0];
          REG_ON_DELAY:       lock_delay   = cfg_data;
          REG_OFF_DELAY:      unlock_delay = cfg_data;
          REG_RESET_TIMEOUT:  seek_timeout = cfg_data;
          default: ;
        endcase
      end
      // results always belong to earlier requests, so compare before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (status_due.size() == 0) begin
          report_mismatch("result with no request waiting", m_axis_tdata, 0);
        end else begin
          due = status_due.pop_front();
          if (seen.drive_on != due.drive_on)
            report_mismatch("drive_on", seen.drive_on, due.drive_on);
          if (seen.actual_state != due.actual_state)
            report_mismatch("actual_state", seen.actual_state, due.actual_state);
          if (seen.error_flag != due.error_flag)
            report_mismatch("error_flag", seen.error_flag, due.error_flag);
          if (seen.commanded_state != due.commanded_state)
            report_mismatch("commanded_state", seen.commanded_state, due.commanded_state);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_controller(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[10], s_axis_tdata[13:11]);
        due.drive_on        = drive;
        due.actual_state    = ctrl;
        due.error_flag      = err;
        due.commanded_state = target;
        status_due.push_back(due);
      end
    end
    pending <= status_due.size();
  end

endmodule

[verif/tb_lid_lock_actuator_controller_unit.sv]
// Testbench top for the lid-lock actuator controller: clock, reset, request
// and configuration stimulus, result back-pressure and the verdict.
// Depends on llac_pkg, llac_checker and lid_lock_actuator_controller_unit.
module tb_lid_lock_actuator_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import llac_pkg::*;

  // codes the block must treat as no-ops
  localparam logic [2:0] CMD_NONE_FIRST = 3'd5;
  localparam logic [2:0] CMD_NONE_LAST  = 3'd7;
  localparam logic [2:0] ST_SPARE_LO    = 3'd6;
  localparam logic [2:0] ST_SPARE_HI    = 3'd7;
  localparam logic [9:0] MS_MAX         = 10'd1023;
  // cycles with no request or result accepted before the run is abandoned
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // elapsed_ms[9:0], sensor_level[10], arg[13:11], zero
  logic [2:0]  s_axis_tuser;   // cmd[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // drive_on[0], actual_state[3:1], error_flag[4],
                               // commanded_state[7:5]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int   mismatches;
  int   pending;
  int   quiet;
  bit   calm;           // set for the last phase: no gaps, no stalls
  logic engaged_level;  // sensor level the block currently reads as locked
  logic [2:0] target_cmd;  // last commanded state we sent, steers the sensor

  lid_lock_actuator_controller_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  llac_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abandon the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: alternate stall bursts with ready stretches, some long
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        // cut a stall short once the last phase starts
        repeat ($urandom_range(1, 18)) if (!calm) @(posedge clk);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 7) == 0 ? 200 : $urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Send one request; return at the edge that accepts it, valid still high.
  // An optional gap drops valid first.
  task automatic send_req(input logic [2:0] cmd, input logic [9:0] ms,
                          input logic lvl, input logic [2:0] arg);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, arg, lvl, ms};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline
  // settle before touching registers.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_cfg(input logic [15:0] ei, input logic lvl, input logic [15:0] on_ms,
                          input logic [15:0] off_ms, input logic [15:0] seek_ms);
    put_reg(REG_ERROR_INTERVAL, ei);
    put_reg(REG_ACTIVE_LEVEL, {15'd0, lvl});
    put_reg(REG_ON_DELAY, on_ms);
    put_reg(REG_OFF_DELAY, off_ms);
    put_reg(REG_RESET_TIMEOUT, seek_ms);
    cfg_we <= 1'b0;
    engaged_level = lvl;
  endtask

  task automatic load_random_cfg();
    load_cfg(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 1500)),
             1'($urandom_range(0, 1)),
             16'($urandom_range(1, 1200)), 16'($urandom_range(1, 1200)),
             16'($urandom_range(1, 4000)));
  endtask

  // One random request. The sensor mostly follows the state we last
  // commanded, so seeks and lock/unlock sequences actually complete.
  task automatic random_item();
    int pick;
    int pct;
    logic [2:0] cmd;
    logic [2:0] arg;
    logic [9:0] ms;
    logic lvl;
    pick = $urandom_range(0, 99);
    ms   = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 120));
    arg  = 3'($urandom_range(0, 7));
    pct  = (target_cmd == ST_ACTIVE) ? 75 : (target_cmd == ST_INACTIVE) ? 25 : 50;
    lvl  = ($urandom_range(0, 99) < pct) ? engaged_level : ~engaged_level;
    if (pick < 64) begin
      cmd = CMD_TICK;
    end else if (pick < 76) begin
      cmd = CMD_SET_CMD;
      if ($urandom_range(0, 4) != 0)
        arg = $urandom_range(0, 1) ? ST_ACTIVE : ST_INACTIVE;
      target_cmd = arg;
    end else if (pick < 80) begin
      cmd = CMD_FORCE;
    end else if (pick < 84) begin
      cmd = CMD_ERR_WRITE;
    end else if (pick < 90) begin
      cmd = CMD_START;
    end else if (pick < 93) begin
      cmd = 3'($urandom_range(CMD_NONE_FIRST, CMD_NONE_LAST));
    end else begin
      cmd = CMD_TICK;
    end
    send_req(cmd, ms, lvl, arg);
  endtask

  task automatic random_run(input int n);
    repeat (n) random_item();
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ERROR_INTERVAL;
    cfg_data      <= '0;
    calm          = 1'b0;
    engaged_level = 1'b1;
    target_cmd    = ST_IDLE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed walk on reset defaults (zero error interval, sensor high = locked)
    send_req(CMD_NONE_FIRST, MS_MAX, 1'b1, ST_SPARE_HI);  // unknown: report only
    send_req(CMD_TICK, MS_MAX, 1'b0, ST_INIT);            // tick in init: no change
    send_req(CMD_NONE_LAST, 10'd0, 1'b0, ST_INIT);
    send_req(CMD_START, 10'd0, 1'b0, ST_INIT);            // start: idle only
    send_req(CMD_TICK, 10'd0, 1'b0, ST_INIT);             // idle -> seeking
    send_req(CMD_TICK, MS_MAX, 1'b1, ST_INIT);            // locked: arm unlock count
    send_req(CMD_TICK, MS_MAX, 1'b0, ST_INIT);            // released past off delay
    send_req(CMD_SET_CMD, 10'd0, 1'b0, ST_ACTIVE);
    send_req(CMD_TICK, 10'd10, 1'b1, ST_INIT);            // inactive -> processing
    send_req(CMD_TICK, 10'd0, 1'b0, ST_INIT);             // zero interval: error at once
    send_req(CMD_ERR_WRITE, 10'd0, 1'b0, 3'd0);           // clear error
    send_req(CMD_TICK, 10'd200, 1'b1, ST_INIT);
    send_req(CMD_TICK, 10'd100, 1'b1, ST_INIT);           // lock confirmed
    send_req(CMD_SET_CMD, 10'd0, 1'b0, ST_INACTIVE);
    send_req(CMD_TICK, 10'd5, 1'b1, ST_INIT);
    send_req(CMD_TICK, MS_MAX, 1'b0, ST_INIT);            // unlock confirmed
    send_req(CMD_SET_CMD, 10'd0, 1'b0, ST_SPARE_LO);      // odd target: hold drive
    send_req(CMD_FORCE, 10'd0, 1'b0, ST_PROC);
    send_req(CMD_TICK, 10'd50, 1'b0, ST_INIT);
    send_req(CMD_FORCE, 10'd0, 1'b0, ST_SPARE_HI);        // odd state: tick is a no-op
    send_req(CMD_TICK, 10'd50, 1'b1, ST_INIT);
    send_req(CMD_ERR_WRITE, 10'd0, 1'b0, 3'd4);           // any nonzero sets error
    send_req(CMD_SET_CMD, 10'd0, 1'b0, ST_INIT);
    send_req(CMD_FORCE, 10'd0, 1'b0, ST_RESET);
    send_req(CMD_TICK, 10'd1, 1'b0, ST_INIT);
    send_req(CMD_TICK, MS_MAX, 1'b0, ST_INIT);            // seek timeout, released
    send_req(CMD_START, 10'd0, 1'b0, ST_INIT);
    send_req(CMD_TICK, 10'd0, 1'b0, ST_INIT);
    send_req(CMD_TICK, 10'd0, 1'b0, ST_INIT);             // re-entry: out on first tick
    drain();

    // Low extremes: zero interval, inverted sensor, minimum delays
    load_cfg(16'd0, 1'b0, 16'd1, 16'd1, 16'd1);
    random_run(250);
    drain();

    // High extremes: saturate the seek timer, then wrap the mismatch timer
    load_cfg(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_FORCE, 10'd0, 1'b0, ST_RESET);
    repeat (135) send_req(CMD_TICK, MS_MAX, engaged_level, ST_INIT);
    send_req(CMD_TICK, 10'd0, ~engaged_level, ST_INIT);
    send_req(CMD_SET_CMD, 10'd0, 1'b0, ST_ACTIVE);
    target_cmd = ST_ACTIVE;
    send_req(CMD_FORCE, 10'd0, 1'b0, ST_PROC);
    repeat (70) send_req(CMD_TICK, MS_MAX, ~engaged_level, ST_INIT);
    random_run(150);
    drain();

    repeat (5) begin
      load_random_cfg();
      random_run(220);
      drain();
    end

    // Final phase runs at full rate on both sides
    load_random_cfg();
    calm = 1'b1;
    random_run(200);
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[lid_lock_actuator_controller_unit.f]
hdl/llac_pkg.sv
hdl/llac_step.sv
hdl/lid_lock_actuator_controller_unit.sv
verif/llac_checker.sv
verif/tb_lid_lock_actuator_controller_unit.sv
